/* design/slrg_pkg.sv */
// Shared types and constants of the shuffled Lehmer generator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package slrg_pkg;

  localparam int WORD_W     = 31;
  localparam int FRAC_W     = 24;
  localparam int FRAC_SHIFT = 7;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [14:0]       LEHMER_MULT  = 15'd16807;
  localparam logic [WORD_W-1:0] LEHMER_MOD   = 31'h7FFF_FFFF;
  localparam int                WARMUP_EXTRA = 8;

  // Register index, taken from paddr[2]
  localparam logic REG_SEED = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM,
    ST_START,
    ST_DIV,
    ST_READ,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load_seed;
    logic warm_step;
    logic draw_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic seed_pending;
    logic warm_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* design/slrg_ram.sv */
// Generic single-port RAM with registered read data.
// Holds the shuffle table; no package dependencies.
`default_nettype none

module slrg_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic                     we,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* design/slrg_ctrl.sv */
// Sequencer of the shuffled Lehmer generator: seeding, warm-up, slot divide, table swap.
// Depends on slrg_pkg for the state, command and status types.
`default_nettype none

module slrg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              restart,
  input  wire slrg_pkg::status_t status,
  output slrg_pkg::cmd_t         cmd
);

  slrg_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slrg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      slrg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (restart || status.seed_pending) begin
            cmd.load_seed = 1'b1;
            state_next    = slrg_pkg::ST_WARM;
          end else begin
            cmd.draw_start = 1'b1;
            state_next     = slrg_pkg::ST_DIV;
          end
        end
      end
      slrg_pkg::ST_WARM: begin
        cmd.warm_step = 1'b1;
        if (status.warm_last) begin
          state_next = slrg_pkg::ST_START;
        end
      end
      slrg_pkg::ST_START: begin
        cmd.draw_start = 1'b1;
        state_next     = slrg_pkg::ST_DIV;
      end
      slrg_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = slrg_pkg::ST_READ;
      end
      slrg_pkg::ST_READ: begin
        // slot address is on the RAM now; data arrives next cycle
        state_next = slrg_pkg::ST_WRITE;
      end
      slrg_pkg::ST_WRITE: begin
        // hold the read until the output register is free
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = slrg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = slrg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/slrg_dp.sv */
// Datapath of the shuffled Lehmer generator: modular multiply, warm-up counter,
// reciprocal-multiply slot index, shuffle table RAM and output register. Uses slrg_pkg, slrg_ram.
`default_nettype none

module slrg_dp #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire slrg_pkg::cmd_t                cmd,
  output slrg_pkg::status_t                  status,
  input  wire logic [slrg_pkg::WORD_W-1:0]   seed,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic      [slrg_pkg::WORD_W-1:0]   raw_value
);

  localparam int AW         = $clog2(TABLE_DEPTH);
  localparam int QBITS      = AW + 1;
  localparam int WARM_STEPS = TABLE_DEPTH + slrg_pkg::WARMUP_EXTRA;
  localparam int CW         = $clog2(WARM_STEPS);
  localparam int unsigned SLOT_DIV = 1 + (32'd2147483646 / TABLE_DEPTH);
  // exact for every 31-bit dividend: shift covers 31 bits plus the divisor size
  localparam int RECIP_SHIFT = 31 + $clog2(SLOT_DIV);
  localparam longint unsigned RECIP_WIDE =
    ((64'd1 << RECIP_SHIFT) + 64'(SLOT_DIV) - 64'd1) / 64'(SLOT_DIV);
  localparam logic [31:0] RECIP = 32'(RECIP_WIDE);

  function automatic logic [slrg_pkg::WORD_W-1:0] lehmer_step(
    input logic [slrg_pkg::WORD_W-1:0] x
  );
    logic [45:0] prod;
    logic [31:0] fold;
    prod = 46'(x) * 46'(slrg_pkg::LEHMER_MULT);
    // 2^31 == 1 mod (2^31 - 1): fold the high part onto the low part
    fold = {1'b0, prod[30:0]} + 32'(prod[45:31]);
    if (fold >= 32'(slrg_pkg::LEHMER_MOD)) begin
      fold = fold - 32'(slrg_pkg::LEHMER_MOD);
    end
    return fold[30:0];
  endfunction

  logic [slrg_pkg::WORD_W-1:0] lcg;
  logic [slrg_pkg::WORD_W-1:0] lcg_next;
  logic [slrg_pkg::WORD_W-1:0] seed_init;
  logic [slrg_pkg::WORD_W-1:0] last_pick;
  logic                        needs_seeding;
  logic [CW-1:0]               pos;
  logic [62:0]                 slot_prod;
  logic [QBITS-1:0]            quot;
  logic [AW-1:0]               slot;
  logic [AW-1:0]               ram_addr;
  logic                        ram_we;
  logic [slrg_pkg::WORD_W-1:0] ram_wdata;
  logic [slrg_pkg::WORD_W-1:0] ram_rdata;
  logic                        out_free;

  assign lcg_next = lehmer_step(lcg);
  // zero and the modulus itself both reduce to zero: start from one
  assign seed_init = (seed == '0 || seed == slrg_pkg::LEHMER_MOD) ? 31'd1 : seed;

  // divide by the slot width as a multiply by its rounded-up reciprocal
  assign slot_prod = 63'(last_pick) * 63'(RECIP);

  assign slot = (quot < QBITS'(TABLE_DEPTH)) ? quot[AW-1:0] : '0;

  assign ram_addr  = cmd.warm_step ? pos[AW-1:0] : slot;
  assign ram_we    = (cmd.warm_step && pos < CW'(TABLE_DEPTH)) || cmd.finish;
  assign ram_wdata = cmd.warm_step ? lcg_next : lcg;

  assign out_free = !out_valid || out_ready;

  assign status.seed_pending = needs_seeding;
  assign status.warm_last    = (pos == '0);
  assign status.out_free     = out_free;

  slrg_ram #(
    .WIDTH (slrg_pkg::WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      lcg <= seed_init;
      pos <= CW'(WARM_STEPS - 1);
    end else if (cmd.warm_step) begin
      lcg <= lcg_next;
      pos <= pos - 1'b1;
    end else if (cmd.draw_start) begin
      lcg <= lcg_next;
    end

    if (cmd.div_step) begin
      quot <= QBITS'(slot_prod >> RECIP_SHIFT);
    end

    if (cmd.finish) begin
      raw_value <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needs_seeding <= 1'b1;
      last_pick     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.warm_step && pos == '0) begin
        // slot 0 gets the last warm-up value; it also seeds the first pick
        last_pick     <= lcg_next;
        needs_seeding <= 1'b0;
      end else if (cmd.finish) begin
        last_pick <= ram_rdata;
      end

      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/shuffled_lehmer_random_generator.sv */
// Top level of the shuffled minimal-standard Lehmer generator: APB seed register,
// controller and datapath. Depends on slrg_pkg, slrg_ctrl, slrg_dp (and slrg_ram).
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+------------------------------
//   config   | psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//   request  | in_valid / in_ready            | restart
//   result   | out_valid / out_ready          | raw_value, unit_fraction
//
// A draw runs in steps: the transfer edge advances the generator, ST_DIV forms the
// slot index by a reciprocal multiply, ST_READ reads the RAM, and the swap edge in
// ST_WRITE loads the result. No new request is taken until the draw has finished.
// A reseed first runs the warm-up steps through the single RAM write port. Reset
// forces a reseed on the first draw. A stalled result holds the finished draw; the
// next request is taken then but completes only once the result register is free.
`default_nettype none

module shuffled_lehmer_random_generator #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [slrg_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [slrg_pkg::DATA_W-1:0]   pwdata,
  output logic      [slrg_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          restart,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [slrg_pkg::WORD_W-1:0]   raw_value,
  output logic      [slrg_pkg::FRAC_W-1:0]   unit_fraction
);

  logic [slrg_pkg::WORD_W-1:0] seed;
  slrg_pkg::cmd_t              cmd;
  slrg_pkg::status_t           status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 31'd1;
    end else if (psel && penable && pwrite && paddr[2] == slrg_pkg::REG_SEED) begin
      seed <= pwdata[slrg_pkg::WORD_W-1:0];
    end
  end

  assign prdata = (paddr[2] == slrg_pkg::REG_SEED) ? {1'b0, seed} : '0;

  assign unit_fraction = raw_value[slrg_pkg::FRAC_SHIFT +: slrg_pkg::FRAC_W];

  slrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .status   (status),
    .cmd      (cmd)
  );

  slrg_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .seed      (seed),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .raw_value (raw_value)
  );

  // one draw in flight: a transfer makes the block busy on the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a draw is in flight");

  // a finished draw never overwrites a result that still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("result register overwritten");

  // table values come from the generator, which never reaches zero or the modulus
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> raw_value != '0 && raw_value != slrg_pkg::LEHMER_MOD)
    else $error("result outside the generator range");

endmodule

`default_nettype wire
